// ===== hdl/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/hrrp_pkg.sv =====
// shared constants and types of the http request referer parser
package hrrp_pkg;

  localparam int MAX_REQUEST_BYTES = 4096;
  localparam int POS_W             = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int FIELD_W           = 12;
  localparam int OUT_DATA_W        = 56;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_BAD  = 2'd1,
    STATUS_LONG = 2'd2
  } status_t;

endpackage

// ===== hdl/http_request_referer_parser.sv =====
// http request line and referer header scanner, top level
// Takes one request byte per word on the s_axis side and gives at most one result word per
// request on the m_axis side. The request must open with "GET ", a non-empty run of uri
// characters, anything up to a space, then " HTTP/" digits "." digits; header lines follow
// (CRLF, lone CR or lone LF end a line) until a blank line or a line that starts with
// "Referer:", whose value after spaces and tabs is measured. A zero byte, or the end of a
// word carrying tlast, ends the request. The result is emitted at the byte that decides the
// outcome; later bytes up to tlast are swallowed, and tlast always rewinds the parser for
// the next request. A byte that arrives after MAX_REQUEST_BYTES bytes with no outcome yet
// gives too long; the implied zero byte at tlast takes no room. Throughput is one byte per
// clock while no result word waits on m_axis: each byte passes an input register, one pass
// through the phase machine (up to four phase changes plus the implied zero byte at tlast)
// and lands in the result register. Back pressure on m_axis stalls the input register only
// while a result waits.
module http_request_referer_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [13:2] uri_offset, [25:14] uri_length, [26] referer_found,
  // [38:27] referer_offset, [50:39] referer_length, [55:51] zero
  output logic [hrrp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int PW = hrrp_pkg::POS_W;
  localparam int FW = hrrp_pkg::FIELD_W;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [3:0] METHOD_LEN  = 4'd4;
  localparam logic [3:0] PROTO_LEN   = 4'd6;
  localparam logic [3:0] REFERER_LEN = 4'd8;

  typedef enum logic [3:0] {
    PH_METHOD, PH_URI, PH_TO_SPACE, PH_PROTO, PH_MAJOR_FIRST, PH_MAJOR,
    PH_MINOR_FIRST, PH_MINOR, PH_LINE_SCAN, PH_LINE_START, PH_REF_MATCH,
    PH_OWS, PH_REF_RUN, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {OUT_NONE, OUT_OK, OUT_BAD, OUT_LONG} outcome_t;

  // parser state carried from byte to byte
  typedef struct packed {
    phase_t        phase;
    logic [3:0]    kw;
    logic          cr_seen;
    logic [FW-1:0] tstart;
    logic [FW-1:0] tlen;
    logic [FW-1:0] rstart;
    logic [FW-1:0] rcnt;
    logic          rseen;
  } pst_t;

  typedef struct packed {
    pst_t     st;
    outcome_t r;
  } feed_res_t;

  localparam pst_t ST_INIT = '{PH_METHOD, 4'd0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0};

  // keyword characters
  function automatic logic [7:0] method_char(input logic [1:0] i);
    logic [7:0] ch;
    unique case (i)
      2'd0: ch = "G";
      2'd1: ch = "E";
      2'd2: ch = "T";
      default: ch = " ";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] proto_char(input logic [2:0] i);
    logic [7:0] ch;
    unique case (i)
      3'd0: ch = " ";
      3'd1: ch = "H";
      3'd2: ch = "T";
      3'd3: ch = "T";
      3'd4: ch = "P";
      default: ch = "/";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] referer_char(input logic [2:0] i);
    logic [7:0] ch;
    unique case (i)
      3'd0: ch = "R";
      3'd1: ch = "e";
      3'd2: ch = "f";
      3'd3: ch = "e";
      3'd4: ch = "r";
      3'd5: ch = "e";
      3'd6: ch = "r";
      default: ch = ":";
    endcase
    return ch;
  endfunction

  function automatic logic dec_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // letters, digits, & ' ( ) * + , - . / _ : ; = @ ! $ % ~
  function automatic logic is_uri(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || dec_digit(c) ||
           ((c >= "&") && (c <= "/")) || (c == "_") || (c == ":") || (c == "~") ||
           (c == ";") || (c == "=") || (c == "@") || (c == "!") || (c == "$") ||
           (c == "%");
  endfunction

  // clamp a position to the 12-bit result range
  function automatic logic [FW-1:0] sat_pos(input logic [PW:0] v);
    logic [PW+FW:0] w;
    w = (PW+FW+1)'(v);
    return (w > (PW+FW+1)'(4095)) ? {FW{1'b1}} : w[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] inc_sat(input logic [FW-1:0] v);
    return (v == {FW{1'b1}}) ? v : v + 1'b1;
  endfunction

  // one byte through the phase machine, with up to four phase changes
  function automatic feed_res_t feed(input pst_t s_in, input logic [7:0] c,
                                     input logic [PW-1:0] pos);
    feed_res_t res;
    pst_t      s;
    outcome_t  r;
    logic      fin;
    logic      nl_skip;
    s = s_in;
    r = OUT_NONE;
    fin = 1'b0;
    nl_skip = 1'b0;
    for (int g = 0; g < 4; g++) begin
      if (!fin) begin
        fin = 1'b1;
        unique case (s.phase)
          PH_METHOD: begin
            if ((s.kw >= METHOD_LEN) || (c != method_char(s.kw[1:0]))) begin
              r = OUT_BAD;
            end else begin
              s.kw = s.kw + 1'b1;
              if (s.kw == METHOD_LEN) begin
                s.phase = PH_URI;
                s.tstart = sat_pos({1'b0, pos} + 1'b1);
                s.tlen = '0;
              end
            end
          end
          PH_URI: begin
            if (is_uri(c)) begin
              s.tlen = inc_sat(s.tlen);
            end else if (s.tlen == '0) begin
              r = OUT_BAD;
            end else begin
              s.phase = PH_TO_SPACE;
              fin = 1'b0;
            end
          end
          PH_TO_SPACE: begin
            if (c == CH_NUL) begin
              r = OUT_BAD;
            end else if (c == CH_SPACE) begin
              s.phase = PH_PROTO;
              s.kw = 4'd1;
            end
          end
          PH_PROTO: begin
            if ((s.kw >= PROTO_LEN) || (c != proto_char(s.kw[2:0]))) begin
              r = OUT_BAD;
            end else begin
              s.kw = s.kw + 1'b1;
              if (s.kw == PROTO_LEN) s.phase = PH_MAJOR_FIRST;
            end
          end
          PH_MAJOR_FIRST: begin
            if (!dec_digit(c)) r = OUT_BAD;
            else s.phase = PH_MAJOR;
          end
          PH_MAJOR: begin
            if (!dec_digit(c)) begin
              if (c != CH_DOT) r = OUT_BAD;
              else s.phase = PH_MINOR_FIRST;
            end
          end
          PH_MINOR_FIRST: begin
            if (!dec_digit(c)) r = OUT_BAD;
            else s.phase = PH_MINOR;
          end
          PH_MINOR: begin
            if (!dec_digit(c)) begin
              s.phase = PH_LINE_SCAN;
              fin = 1'b0;
            end
          end
          PH_LINE_SCAN: begin
            if (c == CH_NUL) begin
              r = OUT_OK;
            end else if (c == CH_CR) begin
              s.cr_seen = 1'b1;
              s.phase = PH_LINE_START;
            end else if (c == CH_LF) begin
              s.cr_seen = 1'b0;
              s.phase = PH_LINE_START;
            end
          end
          PH_LINE_START: begin
            if (s.cr_seen) begin
              s.cr_seen = 1'b0;
              nl_skip = (c == CH_LF);
            end
            if (!nl_skip) begin
              if ((c == CH_CR) || (c == CH_LF)) begin
                r = OUT_OK;
              end else begin
                s.phase = PH_REF_MATCH;
                s.kw = '0;
                fin = 1'b0;
              end
            end
          end
          PH_REF_MATCH: begin
            if ((s.kw < REFERER_LEN) && (c == referer_char(s.kw[2:0]))) begin
              s.kw = s.kw + 1'b1;
              if (s.kw == REFERER_LEN) s.phase = PH_OWS;
            end else begin
              s.phase = PH_LINE_SCAN;
              fin = 1'b0;
            end
          end
          PH_OWS: begin
            if ((c != CH_SPACE) && (c != CH_TAB)) begin
              s.rstart = sat_pos({1'b0, pos});
              s.rcnt = '0;
              s.phase = PH_REF_RUN;
              fin = 1'b0;
            end
          end
          PH_REF_RUN: begin
            if (is_uri(c)) begin
              s.rcnt = inc_sat(s.rcnt);
            end else begin
              s.rseen = 1'b1;
              r = OUT_OK;
            end
          end
          default: begin
          end
        endcase
      end
    end
    res.st = s;
    res.r = r;
    return res;
  endfunction

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // parser state
  pst_t          st;
  logic [PW-1:0] pos;
  logic          sent;

  pst_t          st_next;
  logic [PW-1:0] pos_next;
  logic          sent_next;

  // result register
  logic                   out_valid;
  hrrp_pkg::status_t      out_status;
  logic [FW-1:0]          out_uoff;
  logic [FW-1:0]          out_ulen;
  logic                   out_rfound;
  logic [FW-1:0]          out_roff;
  logic [FW-1:0]          out_rlen;

  feed_res_t  f1;
  feed_res_t  f2;
  outcome_t   res;
  pst_t       st_res;
  logic       advance;
  logic       fire;

  // stage moves when the result register is free or being drained
  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  // real byte, then the implied zero byte that tlast adds
  assign f1 = feed(st, in_byte, pos);
  assign f2 = feed(f1.st, CH_NUL, pos + 1'b1);

  always_comb begin
    st_next   = st;
    pos_next  = pos;
    sent_next = sent;
    res       = OUT_NONE;
    st_res    = st;
    if (!sent) begin
      if (pos >= PW'(hrrp_pkg::MAX_REQUEST_BYTES)) begin
        res = OUT_LONG;
      end else begin
        pos_next = pos + 1'b1;
        if ((f1.r == OUT_NONE) && in_last) begin
          st_res = f2.st;
          res    = f2.r;
        end else begin
          st_res = f1.st;
          res    = f1.r;
        end
      end
      st_next = st_res;
      if (res != OUT_NONE) begin
        sent_next     = 1'b1;
        st_next.phase = PH_DONE;
      end
    end
    // tlast rewinds for the next request
    if (in_last) begin
      st_next   = ST_INIT;
      pos_next  = '0;
      sent_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= ST_INIT;
      pos       <= '0;
      sent      <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
        in_byte  <= s_axis_tdata;
        in_last  <= s_axis_tlast;
      end
      if (fire && (res != OUT_NONE)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        st   <= st_next;
        pos  <= pos_next;
        sent <= sent_next;
        if (res != OUT_NONE) begin
          unique case (res)
            OUT_OK: begin
              out_status <= hrrp_pkg::STATUS_OK;
              out_uoff   <= st_res.tstart;
              out_ulen   <= st_res.tlen;
              out_rfound <= st_res.rseen;
              out_roff   <= st_res.rseen ? st_res.rstart : '0;
              out_rlen   <= st_res.rseen ? st_res.rcnt : '0;
            end
            OUT_BAD: begin
              out_status <= hrrp_pkg::STATUS_BAD;
              out_uoff   <= '0;
              out_ulen   <= '0;
              out_rfound <= 1'b0;
              out_roff   <= '0;
              out_rlen   <= '0;
            end
            default: begin
              out_status <= hrrp_pkg::STATUS_LONG;
              out_uoff   <= '0;
              out_ulen   <= '0;
              out_rfound <= 1'b0;
              out_roff   <= '0;
              out_rlen   <= '0;
            end
          endcase
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_rlen, out_roff, out_rfound, out_ulen, out_uoff,
                          out_status};

endmodule

// ===== hdl/hrrp_checker.sv =====
// port-level checks on the http request referer parser, bound to its top level
`include "assert_macros.svh"

module hrrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [hrrp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic out_stall;
  logic st_ok;
  logic st_known;
  logic rest_zero;
  logic ref_zero;
  logic ulen_set;
  logic rfound;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign st_ok     = (m_axis_tdata[1:0] == hrrp_pkg::STATUS_OK);
  assign st_known  = st_ok || (m_axis_tdata[1:0] == hrrp_pkg::STATUS_BAD) ||
                     (m_axis_tdata[1:0] == hrrp_pkg::STATUS_LONG);
  // everything above status
  assign rest_zero = (m_axis_tdata[hrrp_pkg::OUT_DATA_W-1:2] == '0);
  // referer fields and padding
  assign ref_zero  = (m_axis_tdata[hrrp_pkg::OUT_DATA_W-1:27] == '0);
  assign ulen_set  = (m_axis_tdata[25:14] != '0);
  assign rfound    = m_axis_tdata[26];

  // a stalled result word stays put
  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // status is one of the three defined codes
  `ASSERT_IMPLY(a_status_code, clk, rst, m_axis_tvalid, st_known)

  // a failed request carries no offsets or lengths
  `ASSERT_IMPLY(a_fail_zero, clk, rst, m_axis_tvalid && !st_ok, rest_zero)

  // referer fields only with referer_found, and a good target always has a length
  `ASSERT_IMPLY(a_ok_fields, clk, rst, m_axis_tvalid && st_ok, ulen_set && (rfound || ref_zero))

  // input is never held off while the result side drains
  `ASSERT_IMPLY(a_ready_drain, clk, rst, s_axis_tvalid && m_axis_tready, s_axis_tready)

endmodule

bind http_request_referer_parser hrrp_checker u_hrrp_checker (.*);
